// File: rtl/rgb565_gradient_fill_streamer_macros.svh
// Assertion helpers for the RTL that checks itself.
`ifndef RGB565_GRADIENT_FILL_STREAMER_MACROS_SVH
`define RGB565_GRADIENT_FILL_STREAMER_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define RGFS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rgfs check failed");

// Next-cycle implication, off while reset is held.
`define RGFS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rgfs check failed");

`endif

// File: rtl/rgfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rgfs_pkg;

  localparam int WORD_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CH_MAX_W    = 6;
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_A_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_A_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_B_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_B_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COLOUR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_END_COLOUR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION    = 3'd6;

  // Gradient direction codes; any other code fills with the start colour
  localparam logic [1:0] DIR_HORIZONTAL = 2'd0;
  localparam logic [1:0] DIR_VERTICAL   = 2'd1;

  // Display commands
  localparam logic [WORD_W-1:0] CMD_COLUMN_WINDOW = 16'h002A;
  localparam logic [WORD_W-1:0] CMD_PAGE_WINDOW   = 16'h002B;
  localparam logic [WORD_W-1:0] CMD_MEMORY_WRITE  = 16'h002C;

  // Header positions; HEADER_WORDS marks the pixel phase
  localparam logic [3:0] HP_COL_CMD   = 4'd0;
  localparam logic [3:0] HP_X_LO_HIGH = 4'd1;
  localparam logic [3:0] HP_X_LO_LOW  = 4'd2;
  localparam logic [3:0] HP_X_HI_HIGH = 4'd3;
  localparam logic [3:0] HP_X_HI_LOW  = 4'd4;
  localparam logic [3:0] HP_PAGE_CMD  = 4'd5;
  localparam logic [3:0] HP_Y_LO_HIGH = 4'd6;
  localparam logic [3:0] HP_Y_LO_LOW  = 4'd7;
  localparam logic [3:0] HP_Y_HI_HIGH = 4'd8;
  localparam logic [3:0] HP_Y_HI_LOW  = 4'd9;
  localparam logic [3:0] HEADER_WORDS = 4'd11;

  typedef struct packed {
    logic              need_blend;
    logic              is_data;
    logic              last;
    logic [WORD_W-1:0] word;
  } job_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_DONE = 3'b100
  } back_state_t;

endpackage
`default_nettype wire

// File: rtl/rgfs_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
interface rgfs_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface rgfs_out_if;
  logic        valid;
  logic        ready;
  logic        is_data;
  logic [15:0] bus_word;
  logic        last;
  modport source (output valid, output is_data, output bus_word, output last, input ready);
  modport sink   (input valid, input is_data, input bus_word, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/rgb565_gradient_fill_streamer.sv
// Streams a rectangle fill for a parallel RGB565 display bus, one bus word per
// request: an eleven-word window/write header, then the pixels row by row. A
// front end takes requests and tracks the scan position, a two-entry queue
// holds the classified words, and a back end produces them into an output
// register. Header words and flat pixels (solid mode or a zero span) pass
// straight to the output register; a gradient pixel first passes the three
// per-channel restoring dividers, which produce one quotient bit per cycle
// over COORD_BITS + 6 bits. The front end runs up to two requests ahead of
// the back end. The user must write registers with cfg_we, cfg_index and
// cfg_wdata only while no request is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb565_gradient_fill_streamer_macros.svh"
module rgb565_gradient_fill_streamer #(
  parameter int COORD_BITS = 9
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rgfs_in_if.sink          in_ch,
  rgfs_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import rgfs_pkg::*;

  localparam int JW = $bits(job_ctrl_t) + 2 * COORD_BITS;

  logic [COORD_BITS-1:0] corner_a_x_r, corner_a_y_r, corner_b_x_r, corner_b_y_r;
  logic [15:0]           start_colour_r, end_colour_r;
  logic [1:0]            direction_r;

  q_stat_t               q_stat;
  logic                  q_push, q_pop;
  job_ctrl_t             f_ctrl, b_ctrl;
  logic [COORD_BITS-1:0] f_idx, f_steps, b_idx, b_steps;
  logic [JW-1:0]         q_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_a_x_r   <= '0;
      corner_a_y_r   <= '0;
      corner_b_x_r   <= '0;
      corner_b_y_r   <= '0;
      start_colour_r <= '0;
      end_colour_r   <= '0;
      direction_r    <= DIR_HORIZONTAL;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CORNER_A_X:   corner_a_x_r   <= cfg_wdata[COORD_BITS-1:0];
        CFG_CORNER_A_Y:   corner_a_y_r   <= cfg_wdata[COORD_BITS-1:0];
        CFG_CORNER_B_X:   corner_b_x_r   <= cfg_wdata[COORD_BITS-1:0];
        CFG_CORNER_B_Y:   corner_b_y_r   <= cfg_wdata[COORD_BITS-1:0];
        CFG_START_COLOUR: start_colour_r <= cfg_wdata;
        CFG_END_COLOUR:   end_colour_r   <= cfg_wdata;
        CFG_DIRECTION:    direction_r    <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  rgfs_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .corner_a_x(corner_a_x_r), .corner_a_y(corner_a_y_r),
    .corner_b_x(corner_b_x_r), .corner_b_y(corner_b_y_r),
    .start_colour(start_colour_r), .direction(direction_r),
    .q_stat(q_stat), .q_push(q_push),
    .job_ctrl(f_ctrl), .job_idx(f_idx), .job_steps(f_steps)
  );

  rgfs_queue #(.W(JW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .wr_data({f_ctrl, f_idx, f_steps}),
    .pop(q_pop), .rd_data(q_rd), .q_stat(q_stat)
  );

  assign {b_ctrl, b_idx, b_steps} = q_rd;

  rgfs_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_stat(q_stat), .q_pop(q_pop),
    .job_ctrl(b_ctrl), .job_idx(b_idx), .job_steps(b_steps),
    .start_colour(start_colour_r), .end_colour(end_colour_r),
    .out_ch(out_ch)
  );

  `RGFS_ASSERT_IMP(a_no_push_when_full, clk, rst_n, q_push, !q_stat.full)
  `RGFS_ASSERT_IMP(a_no_pop_when_empty, clk, rst_n, q_pop, !q_stat.empty)
  `RGFS_ASSERT_NXT(a_push_fills_queue, clk, rst_n, q_push && !q_pop, !q_stat.empty)

endmodule
`default_nettype wire

// File: rtl/rgfs_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rgfs_front #(
  parameter int COORD_BITS = 9
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  rgfs_in_if.sink                    in_ch,
  input  wire logic [COORD_BITS-1:0] corner_a_x,
  input  wire logic [COORD_BITS-1:0] corner_a_y,
  input  wire logic [COORD_BITS-1:0] corner_b_x,
  input  wire logic [COORD_BITS-1:0] corner_b_y,
  input  wire logic [15:0]           start_colour,
  input  wire logic [1:0]            direction,
  input  wire rgfs_pkg::q_stat_t     q_stat,
  output logic                       q_push,
  output rgfs_pkg::job_ctrl_t        job_ctrl,
  output logic [COORD_BITS-1:0]      job_idx,
  output logic [COORD_BITS-1:0]      job_steps
);
  import rgfs_pkg::*;

  logic                  active_r, active_nxt;
  logic [3:0]            hdr_r, hdr_nxt;
  logic [COORD_BITS-1:0] col_r, col_nxt;
  logic [COORD_BITS-1:0] row_r, row_nxt;

  logic                  accept;
  logic                  act_eff;
  logic [3:0]            pos_eff;
  logic [COORD_BITS-1:0] col_eff, row_eff;
  logic [COORD_BITS-1:0] x_lo, x_hi, y_lo, y_hi, span_x, span_y;
  logic [WORD_W-1:0]     x_lo_w, x_hi_w, y_lo_w, y_hi_w;
  logic [COORD_BITS-1:0] idx_raw, steps;
  logic                  solid;
  logic                  last_px;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  // A restart acts before the word is produced
  assign act_eff = in_ch.restart || active_r;
  assign pos_eff = in_ch.restart ? HP_COL_CMD : hdr_r;
  assign col_eff = in_ch.restart ? '0 : col_r;
  assign row_eff = in_ch.restart ? '0 : row_r;

  assign x_lo   = (corner_a_x < corner_b_x) ? corner_a_x : corner_b_x;
  assign x_hi   = (corner_a_x < corner_b_x) ? corner_b_x : corner_a_x;
  assign y_lo   = (corner_a_y < corner_b_y) ? corner_a_y : corner_b_y;
  assign y_hi   = (corner_a_y < corner_b_y) ? corner_b_y : corner_a_y;
  assign span_x = x_hi - x_lo;
  assign span_y = y_hi - y_lo;
  assign x_lo_w = WORD_W'(x_lo);
  assign x_hi_w = WORD_W'(x_hi);
  assign y_lo_w = WORD_W'(y_lo);
  assign y_hi_w = WORD_W'(y_hi);

  always_comb begin
    solid   = 1'b0;
    idx_raw = col_eff;
    steps   = span_x;
    case (direction)
      DIR_HORIZONTAL: begin
        idx_raw = col_eff;
        steps   = span_x;
      end
      DIR_VERTICAL: begin
        idx_raw = row_eff;
        steps   = span_y;
      end
      default: solid = 1'b1;
    endcase
  end

  assign last_px = (col_eff >= span_x) && (row_eff >= span_y);

  // Classify the request and build the job for the back end
  always_comb begin
    job_ctrl            = '0;
    job_ctrl.is_data    = 1'b1;
    job_ctrl.need_blend = 1'b0;
    job_idx             = (idx_raw > steps) ? steps : idx_raw;
    job_steps           = steps;
    if (pos_eff < HEADER_WORDS) begin
      case (pos_eff)
        HP_COL_CMD: begin
          job_ctrl.is_data = 1'b0;
          job_ctrl.word    = CMD_COLUMN_WINDOW;
        end
        HP_X_LO_HIGH: job_ctrl.word = {8'h00, x_lo_w[15:8]};
        HP_X_LO_LOW:  job_ctrl.word = {8'h00, x_lo_w[7:0]};
        HP_X_HI_HIGH: job_ctrl.word = {8'h00, x_hi_w[15:8]};
        HP_X_HI_LOW:  job_ctrl.word = {8'h00, x_hi_w[7:0]};
        HP_PAGE_CMD: begin
          job_ctrl.is_data = 1'b0;
          job_ctrl.word    = CMD_PAGE_WINDOW;
        end
        HP_Y_LO_HIGH: job_ctrl.word = {8'h00, y_lo_w[15:8]};
        HP_Y_LO_LOW:  job_ctrl.word = {8'h00, y_lo_w[7:0]};
        HP_Y_HI_HIGH: job_ctrl.word = {8'h00, y_hi_w[15:8]};
        HP_Y_HI_LOW:  job_ctrl.word = {8'h00, y_hi_w[7:0]};
        default: begin
          job_ctrl.is_data = 1'b0;
          job_ctrl.word    = CMD_MEMORY_WRITE;
        end
      endcase
    end else begin
      job_ctrl.word       = start_colour;
      job_ctrl.need_blend = !solid && (steps != '0);
      job_ctrl.last       = last_px;
    end
  end

  assign q_push = accept && act_eff;

  // Advance the scan position
  always_comb begin
    active_nxt = active_r;
    hdr_nxt    = hdr_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (accept) begin
      active_nxt = act_eff;
      hdr_nxt    = pos_eff;
      col_nxt    = col_eff;
      row_nxt    = row_eff;
      if (act_eff) begin
        if (pos_eff < HEADER_WORDS) begin
          hdr_nxt = pos_eff + 4'd1;
        end else if (col_eff >= span_x) begin
          col_nxt = '0;
          if (row_eff >= span_y) begin
            active_nxt = 1'b0;
            hdr_nxt    = HP_COL_CMD;
            row_nxt    = '0;
          end else begin
            row_nxt = row_eff + 1'b1;
          end
        end else begin
          col_nxt = col_eff + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      hdr_r    <= HP_COL_CMD;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      active_r <= active_nxt;
      hdr_r    <= hdr_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/rgfs_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module rgfs_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wr_data,
  input  wire logic         pop,
  output logic [W-1:0]      rd_data,
  output rgfs_pkg::q_stat_t q_stat
);
  import rgfs_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == CW'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign rd_data      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/rgfs_chan_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rgfs_chan_div #(
  parameter int COORD_BITS = 9,
  parameter int CHW        = 5,
  parameter int DW         = 15
) (
  input  wire logic                  clk,
  input  wire logic                  load,
  input  wire logic                  step,
  input  wire logic [CHW-1:0]        s,
  input  wire logic [CHW-1:0]        e,
  input  wire logic [COORD_BITS-1:0] idx,
  input  wire logic [COORD_BITS-1:0] steps,
  output logic [CHW-1:0]             res
);

  logic                  neg_r, neg_nxt;
  logic [DW-1:0]         quo_r, quo_nxt;
  logic [COORD_BITS-1:0] rem_r, rem_nxt;
  logic [COORD_BITS-1:0] steps_r, steps_nxt;

  logic [CHW-1:0]        mag;
  logic [COORD_BITS:0]   trial;
  logic                  fits;

  assign mag   = (e < s) ? (s - e) : (e - s);
  assign trial = {rem_r, quo_r[DW-1]};
  assign fits  = (trial >= {1'b0, steps_r});

  // Restoring divide of |e - s| * idx by steps, one quotient bit per step
  always_comb begin
    neg_nxt   = neg_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    steps_nxt = steps_r;
    if (load) begin
      neg_nxt   = (e < s);
      quo_nxt   = DW'(mag) * DW'(idx);
      rem_nxt   = '0;
      steps_nxt = steps;
    end else if (step) begin
      quo_nxt = {quo_r[DW-2:0], fits};
      rem_nxt = fits ? COORD_BITS'(trial - {1'b0, steps_r}) : trial[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    neg_r   <= neg_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    steps_r <= steps_nxt;
  end

  // Quotient never exceeds |e - s|, so the channel stays in range
  assign res = neg_r ? (s - quo_r[CHW-1:0]) : (s + quo_r[CHW-1:0]);

endmodule
`default_nettype wire

// File: rtl/rgfs_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rgfs_back #(
  parameter int COORD_BITS = 9
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire rgfs_pkg::q_stat_t     q_stat,
  output logic                       q_pop,
  input  wire rgfs_pkg::job_ctrl_t   job_ctrl,
  input  wire logic [COORD_BITS-1:0] job_idx,
  input  wire logic [COORD_BITS-1:0] job_steps,
  input  wire logic [15:0]           start_colour,
  input  wire logic [15:0]           end_colour,
  rgfs_out_if.source                 out_ch
);
  import rgfs_pkg::*;

  localparam int DW = COORD_BITS + CH_MAX_W;
  localparam int CW = $clog2(DW);

  back_state_t       state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_is_data_r, out_is_data_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  logic              out_last_r, out_last_nxt;

  logic              out_free;
  logic              div_load, div_step;
  logic [4:0]        red, blue;
  logic [5:0]        green;

  assign out_free = !out_valid_r || out_ch.ready;

  rgfs_chan_div #(.COORD_BITS(COORD_BITS), .CHW(5), .DW(DW)) u_div_red (
    .clk(clk), .load(div_load), .step(div_step),
    .s(start_colour[15:11]), .e(end_colour[15:11]),
    .idx(job_idx), .steps(job_steps), .res(red)
  );

  rgfs_chan_div #(.COORD_BITS(COORD_BITS), .CHW(6), .DW(DW)) u_div_green (
    .clk(clk), .load(div_load), .step(div_step),
    .s(start_colour[10:5]), .e(end_colour[10:5]),
    .idx(job_idx), .steps(job_steps), .res(green)
  );

  rgfs_chan_div #(.COORD_BITS(COORD_BITS), .CHW(5), .DW(DW)) u_div_blue (
    .clk(clk), .load(div_load), .step(div_step),
    .s(start_colour[4:0]), .e(end_colour[4:0]),
    .idx(job_idx), .steps(job_steps), .res(blue)
  );

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    last_nxt        = last_r;
    q_pop           = 1'b0;
    div_load        = 1'b0;
    div_step        = 1'b0;
    out_valid_nxt   = out_ch.ready ? 1'b0 : out_valid_r;
    out_is_data_nxt = out_is_data_r;
    out_word_nxt    = out_word_r;
    out_last_nxt    = out_last_r;
    case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          if (job_ctrl.need_blend) begin
            q_pop     = 1'b1;
            div_load  = 1'b1;
            last_nxt  = job_ctrl.last;
            cnt_nxt   = '0;
            state_nxt = B_DIV;
          end else if (out_free) begin
            // Header word or flat pixel goes straight to the output
            q_pop           = 1'b1;
            out_valid_nxt   = 1'b1;
            out_is_data_nxt = job_ctrl.is_data;
            out_word_nxt    = job_ctrl.word;
            out_last_nxt    = job_ctrl.last;
          end
        end
      end
      B_DIV: begin
        div_step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CW'(DW - 1)) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_is_data_nxt = 1'b1;
          out_word_nxt    = {red, green, blue};
          out_last_nxt    = last_r;
          state_nxt       = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r         <= cnt_nxt;
    last_r        <= last_nxt;
    out_is_data_r <= out_is_data_nxt;
    out_word_r    <= out_word_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.is_data  = out_is_data_r;
  assign out_ch.bus_word = out_word_r;
  assign out_ch.last     = out_last_r;

endmodule
`default_nettype wire
